// ===== rtl/dbam_pkg.sv =====
// Package for the disk block allocation map.
// Payload structs, controller states, control/status structs and zone helpers.
package dbam_pkg;

  localparam int unsigned TrackW  = 6;
  localparam int unsigned SectorW = 5;
  localparam int unsigned CountW  = 8;
  localparam int unsigned MaskW   = 24;
  localparam int unsigned IntlW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 6;
  localparam int unsigned PosW    = 9;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_MARK  = 3'd2;
  localparam logic [2:0] CMD_FIND  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_TRACK_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIR_TRACK   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTERLEAVE  = 2'd2;

  localparam logic [TrackW-1:0] RST_TRACK_COUNT = 6'd35;
  localparam logic [TrackW-1:0] RST_DIR_TRACK   = 6'h12;
  localparam logic [IntlW-1:0]  RST_INTERLEAVE  = 5'd10;

  localparam logic [SectorW-1:0] ZONE1_SECTORS = 5'd21;
  localparam logic [SectorW-1:0] ZONE2_SECTORS = 5'd19;
  localparam logic [SectorW-1:0] ZONE3_SECTORS = 5'd18;
  localparam logic [SectorW-1:0] ZONE4_SECTORS = 5'd17;
  localparam logic signed [PosW-1:0] ZONE1_LAST = 9'sd17;
  localparam logic signed [PosW-1:0] ZONE2_LAST = 9'sd24;
  localparam logic signed [PosW-1:0] ZONE3_LAST = 9'sd30;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [TrackW-1:0]  track_number;
    logic [SectorW-1:0] sector_number;
    logic               mark_free;
    logic [CountW-1:0]  load_count;
    logic [MaskW-1:0]   load_mask;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [TrackW-1:0]  found_track;
    logic [SectorW-1:0] found_sector;
    logic [CountW-1:0]  track_free_count;
    logic [MaskW-1:0]   track_free_mask;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] value;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic latch;
    logic rd;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic logic [SectorW-1:0] zone_sectors(logic signed [PosW-1:0] t,
                                                      logic signed [PosW-1:0] max_t);
    logic [SectorW-1:0] r;
    if (t <= 9'sd0 || t > max_t) r = '0;
    else if (t <= ZONE1_LAST) r = ZONE1_SECTORS;
    else if (t <= ZONE2_LAST) r = ZONE2_SECTORS;
    else if (t <= ZONE3_LAST) r = ZONE3_SECTORS;
    else r = ZONE4_SECTORS;
    return r;
  endfunction

endpackage

// ===== rtl/dbam_if.sv =====
// Handshake channels of the allocation map: request, response, register write.
// Depends on dbam_pkg for the payload structs.
interface dbam_req_if ();
  logic           valid;
  logic           ready;
  dbam_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dbam_rsp_if ();
  logic           valid;
  logic           ready;
  dbam_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dbam_cfg_if ();
  logic           valid;
  logic           ready;
  dbam_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dbam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbam_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 41
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dbam_ctrl.sv =====
// Controller FSM of the allocation map: accept, read, execute/step, deliver.
// Depends on dbam_pkg.
module dbam_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dbam_pkg::ctl_t ctl_o,
  input  dbam_pkg::sts_t sts_i
);

  dbam_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbam_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbam_pkg::ST_IDLE: if (in_valid_i) state_d = dbam_pkg::ST_READ;
      dbam_pkg::ST_READ: state_d = dbam_pkg::ST_EXEC;
      dbam_pkg::ST_EXEC: state_d = sts_i.done ? dbam_pkg::ST_OUT : dbam_pkg::ST_READ;
      dbam_pkg::ST_OUT:  if (out_ready_i) state_d = dbam_pkg::ST_IDLE;
      default:           state_d = dbam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    unique case (state_q)
      dbam_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.latch = in_valid_i;
      end
      dbam_pkg::ST_READ: ctl_o.rd = 1'b1;
      dbam_pkg::ST_EXEC: ctl_o.exec = 1'b1;
      dbam_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.latch |=> state_q == dbam_pkg::ST_READ)
    else $error("accepted beat not followed by read");
  a_read_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rd |=> ctl_o.exec)
    else $error("read not followed by execute");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input open while result pending");

endmodule

// ===== rtl/dbam_dp.sv =====
// Datapath of the allocation map: track store, valid bits, search stepping,
// sector priority encoder and result register. Depends on dbam_pkg, dbam_ram.
module dbam_dp #(
  parameter int unsigned MAX_TRACKS   = 40,
  parameter int unsigned SECTOR_SLOTS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dbam_pkg::ctl_t                       ctl_i,
  output dbam_pkg::sts_t                       sts_o,
  input  dbam_pkg::req_t                       req_i,
  input  logic [dbam_pkg::TrackW-1:0]          track_count_i,
  input  logic [dbam_pkg::TrackW-1:0]          dir_track_i,
  input  logic [dbam_pkg::IntlW-1:0]           interleave_i,
  output dbam_pkg::rsp_t                       rsp_o
);

  localparam int unsigned Depth = MAX_TRACKS + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SW    = $clog2(SECTOR_SLOTS);
  localparam int unsigned PW    = dbam_pkg::PosW;
  localparam int unsigned CW    = dbam_pkg::CountW;
  localparam int unsigned MW    = dbam_pkg::MaskW;
  localparam logic signed [PW-1:0] MaxT = PW'(MAX_TRACKS);

  dbam_pkg::req_t req_q;
  logic signed [PW-1:0] trk_q, trk_d, size_q, size_d;
  logic [6:0] st_q, st_d;
  logic down_q, down_d, first_q, wrap_q, wrap_d, fb_q, fb_d;
  logic [Depth-1:0] vld_q;
  logic vldrd_q;
  dbam_pkg::rsp_t res_q, res_d;

  logic [SECTOR_SLOTS+CW-1:0] ram_rdata, ram_wdata;
  logic ram_we;
  logic [AW-1:0] raddr;

  logic signed [PW-1:0] dsig, tc, t0, nt;
  logic [dbam_pkg::SectorW-1:0] r, r0;
  logic [6:0] s0;
  logic [SECTOR_SLOTS-1:0] def_mask, ent_mask, new_mask, zmask, cand, hi;
  logic [CW-1:0] ent_cnt, new_cnt;
  logic is_find, t_ok, trk_store, in_loop, hit_ok, brk;
  logic [SW-1:0] hit_lo, hit_hi, hit;
  logic any_lo, any_hi;
  logic [MW-1:0] out_mask;
  logic was;

  assign dsig = PW'(dir_track_i);
  assign tc   = (track_count_i > MAX_TRACKS) ? MaxT : PW'(track_count_i);
  assign is_find = req_q.cmd == dbam_pkg::CMD_FIND;

  // start values for a new beat
  always_comb begin
    t0 = (req_i.track_number == '0) ? dsig - 9'sd1 : PW'(req_i.track_number);
    r0 = dbam_pkg::zone_sectors(t0, MaxT);
    s0 = (req_i.track_number == '0) ? 7'(req_i.sector_number)
                                    : 7'(req_i.sector_number) + 7'(interleave_i);
    if (s0 >= 7'(r0)) s0 = '0;
  end

  assign trk_store = (trk_q >= 9'sd0) && (trk_q <= MaxT);
  assign raddr     = trk_store ? trk_q[AW-1:0] : '0;

  dbam_ram #(.WIDTH(SECTOR_SLOTS + CW), .DEPTH(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_q.track_number[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // entry as stored, or its reset value
  always_comb begin
    r = dbam_pkg::zone_sectors(trk_q, MaxT);
    for (int i = 0; i < SECTOR_SLOTS; i++) def_mask[i] = (i < int'(r));
    if (vldrd_q && req_q.cmd != dbam_pkg::CMD_CLEAR) begin
      ent_mask = ram_rdata[SECTOR_SLOTS+CW-1:CW];
      ent_cnt  = ram_rdata[CW-1:0];
    end else begin
      ent_mask = def_mask;
      ent_cnt  = CW'(r);
    end
  end

  // non-find update
  always_comb begin
    t_ok     = req_q.track_number <= MAX_TRACKS;
    new_mask = ent_mask;
    new_cnt  = ent_cnt;
    ram_we   = 1'b0;
    was      = ent_mask[req_q.sector_number[SW-1:0]];
    case (req_q.cmd)
      dbam_pkg::CMD_LOAD: if (t_ok) begin
        for (int i = 0; i < SECTOR_SLOTS; i++)
          new_mask[i] = (i < MW) ? req_q.load_mask[i] : 1'b0;
        new_cnt = req_q.load_count;
        ram_we  = ctl_i.exec;
      end
      dbam_pkg::CMD_MARK: if (t_ok && req_q.sector_number < SECTOR_SLOTS) begin
        new_mask[req_q.sector_number[SW-1:0]] = req_q.mark_free;
        if (was && !req_q.mark_free) new_cnt = ent_cnt - 8'd1;
        if (!was && req_q.mark_free) new_cnt = ent_cnt + 8'd1;
        ram_we = ctl_i.exec;
      end
      default: ;
    endcase
    ram_wdata = {new_mask, new_cnt};
  end

  // sector search
  always_comb begin
    zmask = def_mask;
    cand  = ent_mask & zmask;
    for (int i = 0; i < SECTOR_SLOTS; i++) hi[i] = cand[i] && (i >= int'(st_q));
    hit_lo = '0;
    hit_hi = '0;
    any_lo = 1'b0;
    any_hi = 1'b0;
    for (int i = SECTOR_SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_lo = SW'(i);
        any_lo = 1'b1;
      end
      if (hi[i]) begin
        hit_hi = SW'(i);
        any_hi = 1'b1;
      end
    end
    hit     = any_hi ? hit_hi : hit_lo;
    in_loop = !fb_q && (trk_q > 9'sd0) && (trk_q <= tc);
    hit_ok  = (fb_q || in_loop) && (st_q < 7'(r)) && any_lo;
  end

  // next track of the walk
  always_comb begin
    nt     = trk_q;
    down_d = down_q;
    size_d = size_q;
    wrap_d = wrap_q;
    brk    = !in_loop;
    if (in_loop) begin
      if (first_q) begin
        if (down_q) begin
          down_d = 1'b0;
          nt = trk_q + size_q;
          if (nt == dsig) nt = nt + 9'sd1;
        end else begin
          down_d = 1'b1;
          nt = trk_q - size_q;
          if (nt == dsig) nt = nt - 9'sd1;
        end
        size_d = size_q + 9'sd1;
        if (nt <= 9'sd0 || nt > tc) brk = 1'b1;
      end else begin
        if (down_q) begin
          nt = trk_q - 9'sd1;
          if (nt == dsig) nt = nt - 9'sd1;
        end else begin
          nt = trk_q + 9'sd1;
          if (nt == dsig) nt = nt + 9'sd1;
        end
        if (nt <= 9'sd0) begin
          down_d = 1'b0;
          nt = dsig + 9'sd1;
          if (wrap_d) brk = 1'b1;
          wrap_d = 1'b1;
        end
        if (!brk && nt > tc) begin
          down_d = 1'b1;
          nt = dsig - 9'sd1;
          if (wrap_d) brk = 1'b1;
          wrap_d = 1'b1;
        end
        if (nt <= 9'sd0 || nt > tc) brk = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MW; i++) out_mask[i] = (i < SECTOR_SLOTS) ? new_mask[i] : 1'b0;
  end

  always_comb begin
    res_d      = res_q;
    trk_d      = trk_q;
    st_d       = st_q;
    fb_d       = fb_q;
    sts_o.done = 1'b1;
    if (!is_find) begin
      res_d.found            = 1'b1;
      res_d.found_track      = req_q.track_number;
      res_d.found_sector     = req_q.sector_number;
      res_d.track_free_count = t_ok ? new_cnt : '0;
      res_d.track_free_mask  = t_ok ? out_mask : '0;
    end else if (hit_ok) begin
      res_d.found            = 1'b1;
      res_d.found_track      = trk_q[dbam_pkg::TrackW-1:0];
      res_d.found_sector     = 5'(hit);
      res_d.track_free_count = ent_cnt;
      res_d.track_free_mask  = out_mask;
    end else if (fb_q) begin
      res_d = '0;
    end else begin
      sts_o.done = 1'b0;
      st_d = '0;
      if (brk) begin
        fb_d  = 1'b1;
        trk_d = dsig;
      end else begin
        trk_d = nt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.exec) begin
      if (req_q.cmd == dbam_pkg::CMD_CLEAR) vld_q <= '0;
      else if (ram_we) vld_q[req_q.track_number[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      req_q   <= req_i;
      first_q <= req_i.track_number == '0;
      trk_q   <= (req_i.cmd == dbam_pkg::CMD_FIND) ? t0 : PW'(req_i.track_number);
      down_q  <= t0 < dsig;
      size_q  <= (t0 < dsig) ? dsig - t0 : t0 - dsig;
      st_q    <= s0;
      wrap_q  <= 1'b0;
      fb_q    <= 1'b0;
    end else if (ctl_i.exec) begin
      res_q  <= res_d;
      trk_q  <= trk_d;
      st_q   <= st_d;
      fb_q   <= fb_d;
      down_q <= down_d;
      size_q <= size_d;
      wrap_q <= wrap_d;
    end
    if (ctl_i.rd) vldrd_q <= trk_store && vld_q[raddr];
  end

  assign rsp_o = res_q;

endmodule

// ===== rtl/disk_block_allocation_map.sv =====
// Top level of the disk block allocation map: register file and channel wiring.
// Depends on dbam_pkg, dbam_if, dbam_ctrl, dbam_dp.
//
//  channel | dir | beat
//  req_i   | in  | cmd, track_number, sector_number, mark_free, load_count, load_mask
//  rsp_o   | out | found, found_track, found_sector, track_free_count, track_free_mask
//  cfg_i   | in  | index (0 track_count, 1 directory_track, 2 sector_interleave), value
//
// Non-find commands take a store read and an execute step, then the output beat. Find
// spends one store read and one priority encode per track visited, plus one more of
// each for the directory fallback. Reset restores the empty-disk map through
// per-track valid bits at once. One beat is in flight at a time; a stalled result
// holds the input closed. Register writes are always taken.
module disk_block_allocation_map #(
  parameter int unsigned MAX_TRACKS   = 40,
  parameter int unsigned SECTOR_SLOTS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  dbam_req_if.sink   req_i,
  dbam_rsp_if.source rsp_o,
  dbam_cfg_if.sink   cfg_i
);

  logic [dbam_pkg::TrackW-1:0] track_count_q, dir_track_q;
  logic [dbam_pkg::IntlW-1:0]  interleave_q;
  dbam_pkg::ctl_t ctl;
  dbam_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q <= dbam_pkg::RST_TRACK_COUNT;
      dir_track_q   <= dbam_pkg::RST_DIR_TRACK;
      interleave_q  <= dbam_pkg::RST_INTERLEAVE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        dbam_pkg::CFG_TRACK_COUNT: track_count_q <= cfg_i.data.value;
        dbam_pkg::CFG_DIR_TRACK:   dir_track_q   <= cfg_i.data.value;
        dbam_pkg::CFG_INTERLEAVE:  interleave_q  <= cfg_i.data.value[dbam_pkg::IntlW-1:0];
        default: ;
      endcase
    end
  end

  dbam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  dbam_dp #(.MAX_TRACKS(MAX_TRACKS), .SECTOR_SLOTS(SECTOR_SLOTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .req_i         (req_i.data),
    .track_count_i (track_count_q),
    .dir_track_i   (dir_track_q),
    .interleave_i  (interleave_q),
    .rsp_o         (rsp_o.data)
  );

endmodule
